// ===== rtl/core/fplh_pkg.sv =====
// ----------------------------------------------------------------------------
// fplh_pkg
// Types, codes and a helper function shared by the field peak histogram block.
// ----------------------------------------------------------------------------
package fplh_pkg;

	typedef enum logic [1:0] {
		FUNC_SAMPLE    = 2'd0,
		FUNC_WAVE_END  = 2'd1,
		FUNC_SLICE_END = 2'd2,
		FUNC_READ      = 2'd3
	} func_t;

	localparam logic REG_MIN_WAVE_SAMPLES = 1'b0;
	localparam logic REG_NOISE_SHIFT      = 1'b1;

	localparam logic [7:0] MIN_WAVE_SAMPLES_RST = 8'd7;
	localparam logic [3:0] NOISE_SHIFT_RST      = 4'd4;

	localparam logic [15:0] WAVE_MIN_RST = 16'hFFFF;
	localparam logic [7:0]  SAMPLES_MAX  = 8'd255;

	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [7:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

	// Number of bits needed to hold the value, zero for zero.
	function automatic logic [4:0] bit_len16(input logic [15:0] v);
		logic [4:0] len;
		len = 5'd0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				len = 5'(i + 1);
			end
		end
		return len;
	endfunction

endpackage

// ===== rtl/core/fplh_lane.sv =====
// ----------------------------------------------------------------------------
// fplh_lane
// One axis lane: registers the absolute value of a signed 12-bit reading.
// ----------------------------------------------------------------------------
module fplh_lane (
	input  logic               clk,
	input  logic               en,
	input  logic signed [11:0] raw,
	output logic [11:0]        abs_s1
);

	logic [11:0] abs_val;

	assign abs_val = raw[11] ? 12'(12'd0 - 12'(raw)) : 12'(raw);

	always_ff @(posedge clk) begin
		if (en) begin
			abs_s1 <= abs_val;
		end
	end

endmodule

// ===== rtl/core/fplh_div.sv =====
// ----------------------------------------------------------------------------
// fplh_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module fplh_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fplh_pkg::div_req_t req,
	output fplh_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [7:0]  rem_q;
	logic [15:0] dq_q;
	logic [7:0]  dvs_q;
	logic [8:0]  trial;
	logic        ge;
	logic [7:0]  next_rem;

	assign trial    = {rem_q, dq_q[15]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign next_rem = ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(fplh_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 8'd0;
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= next_rem;
			dq_q  <= {dq_q[14:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule

// ===== rtl/core/fplh_hist.sv =====
// ----------------------------------------------------------------------------
// fplh_hist
// Histogram bucket bank with one increment port and one read port.
// ----------------------------------------------------------------------------
module fplh_hist #(
	parameter int NUM_BUCKETS = 10,
	parameter int COUNT_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           inc,
	input  logic [$clog2(NUM_BUCKETS)-1:0] inc_idx,
	input  logic [$clog2(NUM_BUCKETS)-1:0] rd_idx,
	output logic [COUNT_BITS-1:0]          rd_cnt
);

	logic [COUNT_BITS-1:0] bucket_q [NUM_BUCKETS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				bucket_q[i] <= '0;
			end
		end else if (inc) begin
			bucket_q[inc_idx] <= bucket_q[inc_idx] + COUNT_BITS'(1);
		end
	end

	assign rd_cnt = bucket_q[rd_idx];

endmodule

// ===== rtl/core/field_peak_log2_histogram_top.sv =====
// ----------------------------------------------------------------------------
// field_peak_log2_histogram_top
// Magnetometer peak-to-peak histogram with a stream port and a register port.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A sample, wave end or read item passes
// through the execute and output states before the next one is accepted. A
// slice end item with accepted waves also passes the divide state, where the
// divider produces one quotient bit per cycle, and the histogram state. A
// finished result waits in the output register while the next item is taken in.
module field_peak_log2_histogram_top #(
	parameter int NUM_BUCKETS = 10,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // axis_x, axis_y, axis_z, read_index
	input  logic [2:0]  s_tuser,   // func, sample_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // magnitude, bucket_number, bucket_count, zero pad
	output logic [1:0]  m_tuser,   // wave_accepted, bucket_updated
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int BW = $clog2(NUM_BUCKETS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_HIST,
		ST_OUT
	} state_t;

	state_t                  state_q;
	fplh_pkg::func_t         func_q;
	logic                    valid_q;
	logic [3:0]              read_index_q;
	logic [7:0]              min_wave_q;
	logic [3:0]              nshift_q;
	logic [15:0]             wave_max_q;
	logic [15:0]             wave_min_q;
	logic [7:0]              wave_samples_q;
	logic [15:0]             slice_sum_q;
	logic [7:0]              slice_waves_q;
	logic [BW-1:0]           bucket_q;
	logic [12:0]             res_mag_q;
	logic                    res_acc_q;
	logic                    res_upd_q;
	logic [3:0]              res_num_q;
	logic [31:0]             res_cnt_q;
	logic                    m_tvalid_q;
	logic [12:0]             m_mag_q;
	logic                    m_acc_q;
	logic                    m_upd_q;
	logic [3:0]              m_num_q;
	logic [31:0]             m_cnt_q;
	logic                    in_acc;
	logic [11:0]             abs_x_s1;
	logic [11:0]             abs_y_s1;
	logic [11:0]             abs_z_s1;
	logic [12:0]             mag;
	logic [15:0]             avg;
	logic [4:0]              len;
	logic                    idx_in_range;
	logic [BW-1:0]           hist_rd_idx;
	logic [COUNT_BITS-1:0]   hist_rd;
	logic [COUNT_BITS-1:0]   hist_next;
	logic                    hist_inc;
	logic                    cfg_wr;
	fplh_pkg::div_req_t      div_req;
	fplh_pkg::div_rsp_t      div_rsp;

	assign in_acc = s_tvalid && s_tready;

	fplh_lane u_lane_x (.clk(clk), .en(in_acc), .raw(s_tdata[11:0]),  .abs_s1(abs_x_s1));
	fplh_lane u_lane_y (.clk(clk), .en(in_acc), .raw(s_tdata[23:12]), .abs_s1(abs_y_s1));
	fplh_lane u_lane_z (.clk(clk), .en(in_acc), .raw(s_tdata[35:24]), .abs_s1(abs_z_s1));

	assign mag = 13'(abs_x_s1) + 13'(abs_y_s1) + 13'(abs_z_s1);

	assign div_req.start    = (state_q == ST_EXEC) && (func_q == fplh_pkg::FUNC_SLICE_END)
		&& (slice_waves_q != 8'd0);
	assign div_req.dividend = slice_sum_q;
	assign div_req.divisor  = slice_waves_q;

	fplh_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign avg = div_rsp.quotient >> nshift_q;
	assign len = fplh_pkg::bit_len16(avg);

	assign idx_in_range = int'(read_index_q) < NUM_BUCKETS;
	assign hist_rd_idx  = (state_q == ST_HIST) ? bucket_q : BW'(read_index_q);
	assign hist_inc     = (state_q == ST_HIST);
	assign hist_next    = hist_rd + COUNT_BITS'(1);

	fplh_hist #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.COUNT_BITS (COUNT_BITS)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (hist_inc),
		.inc_idx(bucket_q),
		.rd_idx (hist_rd_idx),
		.rd_cnt (hist_rd)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == fplh_pkg::REG_NOISE_SHIFT) ? {28'd0, nshift_q}
		: {24'd0, min_wave_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_wave_q <= fplh_pkg::MIN_WAVE_SAMPLES_RST;
			nshift_q   <= fplh_pkg::NOISE_SHIFT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == fplh_pkg::REG_NOISE_SHIFT) begin
				nshift_q <= pwdata[3:0];
			end else begin
				min_wave_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			func_q         <= fplh_pkg::FUNC_SAMPLE;
			valid_q        <= 1'b0;
			read_index_q   <= 4'd0;
			wave_max_q     <= 16'd0;
			wave_min_q     <= fplh_pkg::WAVE_MIN_RST;
			wave_samples_q <= 8'd0;
			slice_sum_q    <= 16'd0;
			slice_waves_q  <= 8'd0;
			bucket_q       <= '0;
			res_mag_q      <= 13'd0;
			res_acc_q      <= 1'b0;
			res_upd_q      <= 1'b0;
			res_num_q      <= 4'd0;
			res_cnt_q      <= 32'd0;
			m_tvalid_q     <= 1'b0;
			m_mag_q        <= 13'd0;
			m_acc_q        <= 1'b0;
			m_upd_q        <= 1'b0;
			m_num_q        <= 4'd0;
			m_cnt_q        <= 32'd0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						func_q       <= fplh_pkg::func_t'(s_tuser[1:0]);
						valid_q      <= s_tuser[2];
						read_index_q <= s_tdata[39:36];
						state_q      <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_mag_q <= (func_q == fplh_pkg::FUNC_SAMPLE && valid_q) ? mag : 13'd0;
					res_acc_q <= (func_q == fplh_pkg::FUNC_WAVE_END)
						&& (wave_samples_q > min_wave_q);
					res_upd_q <= 1'b0;
					res_num_q <= (func_q == fplh_pkg::FUNC_READ) ? read_index_q : 4'd0;
					res_cnt_q <= (func_q == fplh_pkg::FUNC_READ && idx_in_range)
						? 32'(hist_rd) : 32'd0;
					state_q   <= div_req.start ? ST_DIV : ST_OUT;
					case (func_q)
						fplh_pkg::FUNC_SAMPLE: begin
							if (valid_q) begin
								if (16'(mag) > wave_max_q) begin
									wave_max_q <= 16'(mag);
								end
								if (16'(mag) < wave_min_q) begin
									wave_min_q <= 16'(mag);
								end
								if (wave_samples_q != fplh_pkg::SAMPLES_MAX) begin
									wave_samples_q <= wave_samples_q + 8'd1;
								end
							end
						end
						fplh_pkg::FUNC_WAVE_END: begin
							if (wave_samples_q > min_wave_q) begin
								slice_sum_q   <= slice_sum_q + (wave_max_q - wave_min_q);
								slice_waves_q <= slice_waves_q + 8'd1;
							end
							wave_max_q     <= 16'd0;
							wave_min_q     <= fplh_pkg::WAVE_MIN_RST;
							wave_samples_q <= 8'd0;
						end
						fplh_pkg::FUNC_SLICE_END: begin
							if (slice_waves_q == 8'd0) begin
								slice_sum_q <= 16'd0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (int'(len) > NUM_BUCKETS - 1) begin
							bucket_q <= BW'(NUM_BUCKETS - 1);
						end else begin
							bucket_q <= BW'(len);
						end
						state_q <= ST_HIST;
					end
				end
				ST_HIST: begin
					res_upd_q     <= 1'b1;
					res_num_q     <= 4'(bucket_q);
					res_cnt_q     <= 32'(hist_next);
					slice_sum_q   <= 16'd0;
					slice_waves_q <= 8'd0;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_mag_q    <= res_mag_q;
						m_acc_q    <= res_acc_q;
						m_upd_q    <= res_upd_q;
						m_num_q    <= res_num_q;
						m_cnt_q    <= res_cnt_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, m_cnt_q, m_num_q, m_mag_q};
	assign m_tuser  = {m_upd_q, m_acc_q};

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("Divider finished outside the divide state.");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("A second item was taken while one is in work.");

	a_slice_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HIST |=> slice_waves_q == 8'd0 && slice_sum_q == 16'd0)
		else $error("Slice state not cleared after a bucket update.");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tdata[12:0] == 13'd0)
		else $error("Wave end result carries fields of another function.");

	a_start_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> state_q == ST_DIV)
		else $error("Divider started without entering the divide state.");

endmodule
